@@ rtl/core/ccs_pkg.sv @@
// ---------------------------------------------------------------------------
// ccs_pkg: shared types and constants for the C comment stripper
// Scanner state, per-item result bundle and character codes.
// ---------------------------------------------------------------------------
package ccs_pkg;

    localparam int MaxEmit = 4;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSL    = 8'h5C;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_BLOCK  = 3'd1,
        MODE_LINE   = 3'd2,
        MODE_CHAR   = 3'd3,
        MODE_STRING = 3'd4
    } mode_t;

    typedef struct packed {
        mode_t mode;
        logic  esc;
        logic  slash;
        logic  star;
        logic  bsl;
        logic  empty;
    } scan_t;

    // Bytes produced by one input beat; cnt is 0 to MaxEmit.
    typedef struct packed {
        logic [2:0]                cnt;
        logic [MaxEmit-1:0][7:0]   bytes;
    } res_t;

endpackage

@@ rtl/core/c_comment_stripper.sv @@
// ---------------------------------------------------------------------------
// c_comment_stripper: byte-stream C comment stripper with line splicing
// Input register, lexing step and output sequencer.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one source byte per beat in tdata; tlast marks the end of
//   the file (tdata is then ignored). m_axis carries cleaned bytes; tlast is
//   set on the last byte produced by a given input beat. An input beat may
//   produce no output bytes at all (line comments, held slash or backslash).
//   An accepted beat is held in the input register, then lexed and, once the
//   sequencer can take it, loaded into the result register, from which its
//   bytes are offered on m_axis. Throughput is one input beat per cycle while
//   each beat yields at most one byte and m_axis_tready is high; a beat that
//   yields more bytes holds the input side until its last byte is taken, set
//   by the single output port of the sequencer. Beats yielding no bytes pass
//   at one per cycle while the sequencer is idle.
//   Reset puts the scanner in normal code mode at the start of an empty line
//   and empties both registers. When m_axis_tready is low, the held byte
//   stays on the output and s_axis_tready drops once the input register is
//   full; no beat is lost.
// ---------------------------------------------------------------------------
module c_comment_stripper (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // end_of_input
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast    // last_of_run
);

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          in_end_reg;
    logic          load_ready;
    logic          advance;
    ccs_pkg::res_t res;

    assign advance       = in_valid_reg && load_ready;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_end_reg  <= s_axis_tlast;
        end
    end

    ccs_lex u_lex (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .in_byte (in_byte_reg),
        .in_end  (in_end_reg),
        .res     (res)
    );

    ccs_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .load_valid    (in_valid_reg),
        .load_ready    (load_ready),
        .load_res      (res),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ rtl/core/ccs_lex.sv @@
// ---------------------------------------------------------------------------
// ccs_lex: scanner state and per-byte lexing step
// Holds the scanner state and computes the cleaned bytes for one beat.
// ---------------------------------------------------------------------------
module ccs_lex (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step_en,
    input  logic [7:0]    in_byte,
    input  logic          in_end,
    output ccs_pkg::res_t res
);

    typedef struct packed {
        ccs_pkg::scan_t st;
        ccs_pkg::res_t  r;
    } work_t;

    ccs_pkg::scan_t state_reg;
    ccs_pkg::scan_t state_next;
    work_t          w;

    function automatic work_t emit(work_t x, logic [7:0] b);
        work_t y;
        y = x;
        if (x.r.cnt < 3'(ccs_pkg::MaxEmit))
        begin
            y.r.bytes[x.r.cnt[1:0]] = b;
            y.r.cnt = x.r.cnt + 3'd1;
        end
        return y;
    endfunction

    function automatic work_t plain_char(work_t x, logic [7:0] c);
        work_t y;
        y = x;
        if (c == ccs_pkg::CH_SLASH)
        begin
            y.st.slash = 1'b1;
        end
        else if (c == ccs_pkg::CH_QUOTE)
        begin
            y = emit(y, c);
            y.st.mode = ccs_pkg::MODE_CHAR;
            y.st.esc = 1'b0;
        end
        else if (c == ccs_pkg::CH_DQUOTE)
        begin
            y = emit(y, c);
            y.st.mode = ccs_pkg::MODE_STRING;
            y.st.esc = 1'b0;
        end
        else
        begin
            y = emit(y, c);
        end
        return y;
    endfunction

    function automatic work_t lex_char(work_t x, logic [7:0] c);
        work_t      y;
        logic [7:0] close;
        y = x;
        close = (x.st.mode == ccs_pkg::MODE_CHAR) ? ccs_pkg::CH_QUOTE : ccs_pkg::CH_DQUOTE;
        case (x.st.mode)
            ccs_pkg::MODE_BLOCK:
            begin
                y = emit(y, ccs_pkg::CH_SPACE);
                if (x.st.star && c == ccs_pkg::CH_SLASH)
                begin
                    y.st.mode = ccs_pkg::MODE_NORMAL;
                    y.st.star = 1'b0;
                end
                else
                begin
                    y.st.star = (c == ccs_pkg::CH_STAR);
                end
            end
            ccs_pkg::MODE_LINE:
            begin
                y = x;  // drop
            end
            ccs_pkg::MODE_CHAR, ccs_pkg::MODE_STRING:
            begin
                y = emit(y, c);
                if (x.st.esc)
                begin
                    y.st.esc = 1'b0;
                end
                else if (c == ccs_pkg::CH_BSL)
                begin
                    y.st.esc = 1'b1;
                end
                else if (c == close)
                begin
                    y.st.mode = ccs_pkg::MODE_NORMAL;
                end
            end
            default:
            begin
                if (x.st.slash)
                begin
                    y.st.slash = 1'b0;
                    if (c == ccs_pkg::CH_SLASH)
                    begin
                        y.st.mode = ccs_pkg::MODE_LINE;
                    end
                    else if (c == ccs_pkg::CH_STAR)
                    begin
                        y = emit(y, ccs_pkg::CH_SPACE);
                        y = emit(y, ccs_pkg::CH_SPACE);
                        y.st.mode = ccs_pkg::MODE_BLOCK;
                        y.st.star = 1'b0;
                    end
                    else
                    begin
                        y = emit(y, ccs_pkg::CH_SLASH);
                        y = plain_char(y, c);
                    end
                end
                else
                begin
                    y = plain_char(y, c);
                end
            end
        endcase
        return y;
    endfunction

    // Reset line-level state, keep an open block comment.
    function automatic work_t clear_line(work_t x);
        work_t y;
        y = x;
        if (x.st.mode != ccs_pkg::MODE_BLOCK)
        begin
            y.st.mode = ccs_pkg::MODE_NORMAL;
        end
        y.st.esc = 1'b0;
        y.st.star = 1'b0;
        y.st.slash = 1'b0;
        return y;
    endfunction

    function automatic work_t end_line(work_t x);
        work_t y;
        y = x;
        if (x.st.slash)
        begin
            y = emit(y, ccs_pkg::CH_SLASH);
        end
        if (x.st.empty)
        begin
            y = emit(y, ccs_pkg::CH_SPACE);
        end
        y = emit(y, ccs_pkg::CH_NL);
        y = clear_line(y);
        y.st.empty = 1'b1;
        return y;
    endfunction

    always_comb
    begin
        w.st = state_reg;
        w.r = '0;
        if (in_end)
        begin
            if (state_reg.bsl)
            begin
                w.st.bsl = 1'b0;
                w.st.empty = 1'b0;
                w = lex_char(w, ccs_pkg::CH_BSL);
            end
            if (!w.st.empty)
            begin
                w = end_line(w);
            end
            else
            begin
                w = clear_line(w);
            end
        end
        else if (state_reg.bsl)
        begin
            w.st.bsl = 1'b0;
            if (in_byte != ccs_pkg::CH_NL)
            begin
                w.st.empty = 1'b0;
                w = lex_char(w, ccs_pkg::CH_BSL);
                w = lex_char(w, in_byte);
            end
        end
        else if (in_byte == ccs_pkg::CH_BSL)
        begin
            w.st.bsl = 1'b1;
        end
        else if (in_byte == ccs_pkg::CH_NL)
        begin
            w = end_line(w);
        end
        else
        begin
            w.st.empty = 1'b0;
            w = lex_char(w, in_byte);
        end
        state_next = w.st;
        res = w.r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode  <= ccs_pkg::MODE_NORMAL;
            state_reg.esc   <= 1'b0;
            state_reg.slash <= 1'b0;
            state_reg.star  <= 1'b0;
            state_reg.bsl   <= 1'b0;
            state_reg.empty <= 1'b1;
        end
        else if (step_en)
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/ccs_emit.sv @@
// ---------------------------------------------------------------------------
// ccs_emit: result register and output sequencer
// Holds the bytes of one input beat and sends them out one beat at a time.
// ---------------------------------------------------------------------------
module ccs_emit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load_valid,
    output logic          load_ready,
    input  ccs_pkg::res_t load_res,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [7:0]    m_axis_tdata,   // [7:0] out_byte
    output logic          m_axis_tlast    // last_of_run
);

    logic [ccs_pkg::MaxEmit-1:0][7:0] bytes_reg;
    logic [2:0]                       cnt_reg;
    logic [1:0]                       idx_reg;
    logic                             busy_reg;
    logic                             take;
    logic                             last;
    logic                             load;

    assign last          = ({1'b0, idx_reg} + 3'd1) == cnt_reg;
    assign take          = busy_reg && m_axis_tready;
    assign load_ready    = !busy_reg || (m_axis_tready && last);
    assign load          = load_valid && load_ready;
    assign m_axis_tvalid = busy_reg;
    assign m_axis_tdata  = bytes_reg[idx_reg];
    assign m_axis_tlast  = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (load)
        begin
            // A beat with no bytes leaves the sequencer idle.
            busy_reg <= (load_res.cnt != 3'd0);
            idx_reg  <= '0;
            cnt_reg  <= load_res.cnt;
        end
        else if (take)
        begin
            if (last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= load_res.bytes;
        end
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ({1'b0, idx_reg} < cnt_reg))
        else $error("output index beyond byte count");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !last) |=> (busy_reg && idx_reg == $past(idx_reg) + 2'd1))
        else $error("sequencer did not advance to next byte");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (take && last && !load_valid) |=> !busy_reg)
        else $error("sequencer busy after last byte");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (load && load_res.cnt != 3'd0) |=> (busy_reg && idx_reg == 2'd0))
        else $error("loaded run not started at first byte");

endmodule
